// File: src/arpir_pkg.sv
// Shared constants, types and codes of the ARP/ICMP reply resolution table.
package arpir_pkg;

    localparam int TABLE_SLOTS     = 16;
    localparam int MAX_FRAME_BYTES = 1518;
    localparam int SLOT_W          = $clog2(TABLE_SLOTS);
    localparam int POS_W           = 11;

    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [63:0] ARP_REPLY_HDR = 64'h0001080006040002;
    localparam logic [POS_W-1:0] ETH_MIN_LEN = POS_W'(42);

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_UNREACH = 2'd1;
    localparam logic [1:0] KIND_ARP     = 2'd2;
    localparam logic [1:0] KIND_ECHO    = 2'd3;

    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0] ICMP_UNREACH    = 8'd3;
    localparam logic [7:0] ICMP_TIME_EXC   = 8'd11;
    localparam logic [7:0] IP_PROTO_ICMP   = 8'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic byte_en;
        logic insert_en;
        logic query_en;
        logic lookup_en;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_record;

endpackage

// File: src/arpir_ctrl.sv
// Controller state machine: input handshake, frame end insert, lookup sequencing.
module arpir_ctrl import arpir_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_s_tlast,
    input  logic i_s_cmd,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_s_cmd) n_state = ST_LOOKUP;
                else if (w_accept && i_s_tlast) n_state = ST_INSERT;
            end
            ST_INSERT: n_state = ST_IDLE;
            ST_LOOKUP: begin
                if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_cmd.byte_en  = w_accept && !i_s_cmd;
                o_cmd.query_en = w_accept && i_s_cmd;
            end
            ST_INSERT: o_cmd.insert_en = 1'b1;
            ST_LOOKUP: o_cmd.lookup_en = !r_out_valid || i_m_tready;
            default: o_s_tready = 1'b0;
        endcase
    end

    // hold the result until the downstream side takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.lookup_en) n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_insert_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_INSERT |=> r_state == ST_IDLE) else $error("insert overran");
    a_lookup_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup_en |-> (!r_out_valid || i_m_tready)) else $error("result overwritten");
    a_valid_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.lookup_en)) else $error("stray result");

endmodule

// File: src/arpir_parse.sv
// Header capture of the frame in progress and record decision at frame end.
module arpir_parse import arpir_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_byte,
    output t_record    o_rec
);

    logic [POS_W-1:0] r_pos;
    logic [15:0] r_otype, r_itype;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto, r_icmp, r_qproto;
    logic [63:0] r_arph;
    logic [47:0] r_smac;
    logic [31:0] r_sip, r_qdst;

    logic             w_tagged, w_take;
    logic [15:0]      w_etype;
    logic [POS_W-1:0] w_l3, w_p, w_h, w_fh;
    logic [3:0]       w_ihl_eff;

    assign w_tagged  = (r_otype == ETYPE_VLAN);
    assign w_l3      = w_tagged ? POS_W'(18) : POS_W'(14);
    assign w_etype   = w_tagged ? r_itype : r_otype;
    assign w_p       = r_pos - w_l3;
    assign w_take    = i_cmd.byte_en && (r_pos < POS_W'(MAX_FRAME_BYTES));
    assign w_ihl_eff = (w_p == '0) ? i_byte[3:0] : r_ihl;
    assign w_h       = POS_W'({w_ihl_eff, 2'b00});
    assign w_fh      = POS_W'({r_ihl, 2'b00});

    // capture header fields byte by byte, clear after the insert cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.insert_en) begin
            r_pos <= '0; r_otype <= '0; r_itype <= '0; r_ihl <= '0;
            r_proto <= '0; r_icmp <= '0; r_qproto <= '0;
            r_arph <= '0; r_smac <= '0; r_sip <= '0; r_qdst <= '0;
        end else if (w_take) begin
            r_pos <= r_pos + POS_W'(1);
            if (r_pos == POS_W'(12) || r_pos == POS_W'(13)) r_otype <= {r_otype[7:0], i_byte};
            if (w_tagged && (r_pos == POS_W'(16) || r_pos == POS_W'(17)))
                r_itype <= {r_itype[7:0], i_byte};
            if (r_pos >= POS_W'(14) && r_pos >= w_l3) begin
                if (w_etype == ETYPE_ARP) begin
                    if (w_p < POS_W'(8)) r_arph <= {r_arph[55:0], i_byte};
                    else if (w_p < POS_W'(14)) r_smac <= {r_smac[39:0], i_byte};
                    else if (w_p < POS_W'(18)) r_sip <= {r_sip[23:0], i_byte};
                end else if (w_etype == ETYPE_IPV4) begin
                    r_ihl <= w_ihl_eff;
                    if (w_p == POS_W'(9)) r_proto <= i_byte;
                    if (w_p >= POS_W'(12) && w_p < POS_W'(16)) r_sip <= {r_sip[23:0], i_byte};
                    if (w_p == w_h) r_icmp <= i_byte;
                    if (w_p == w_h + POS_W'(17)) r_qproto <= i_byte;
                    if (w_p >= w_h + POS_W'(24) && w_p < w_h + POS_W'(28))
                        r_qdst <= {r_qdst[23:0], i_byte};
                end
            end
        end
    end

    // decide what the finished frame records
    always_comb begin
        o_rec = '0;
        if (r_pos >= ETH_MIN_LEN) begin
            if (w_etype == ETYPE_ARP) begin
                if (r_pos >= w_l3 + POS_W'(18) && r_arph == ARP_REPLY_HDR) begin
                    o_rec.valid = 1'b1;
                    o_rec.kind  = KIND_ARP;
                    o_rec.ip    = r_sip;
                    o_rec.mac   = r_smac;
                end
            end else if (w_etype == ETYPE_IPV4 && r_proto == IP_PROTO_ICMP &&
                         r_pos >= w_l3 + w_fh + POS_W'(1)) begin
                if (r_icmp == ICMP_ECHO_REPLY) begin
                    o_rec.valid = 1'b1;
                    o_rec.kind  = KIND_ECHO;
                    o_rec.ip    = r_sip;
                end else if ((r_icmp == ICMP_UNREACH || r_icmp == ICMP_TIME_EXC) &&
                             r_pos >= w_l3 + w_fh + POS_W'(28) &&
                             r_qproto == IP_PROTO_ICMP) begin
                    o_rec.valid = 1'b1;
                    o_rec.kind  = KIND_UNREACH;
                    o_rec.ip    = r_qdst;
                end
            end
        end
    end

endmodule

// File: src/arpir_table.sv
// Resolution table keyed by IP, with insert, lookup-and-remove and result register.
module arpir_table import arpir_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_record     i_rec,
    input  logic [31:0] i_query,
    output logic [1:0]  o_kind,
    output logic [47:0] o_mac,
    output logic [31:0] o_ip,
    output logic        o_overflow
);

    logic [TABLE_SLOTS-1:0] r_valid;
    logic [31:0] r_ip   [TABLE_SLOTS];
    logic [47:0] r_mac  [TABLE_SLOTS];
    logic [1:0]  r_kind [TABLE_SLOTS];
    logic [31:0] r_query;
    logic        r_overflow;
    logic [1:0]  r_okind;
    logic [47:0] r_omac;
    logic [31:0] r_oip;
    logic        r_oovf;

    logic [31:0]       w_key;
    logic              w_hit, w_free;
    logic [SLOT_W-1:0] w_hit_idx, w_free_idx, w_ins_idx;

    assign w_key = i_cmd.lookup_en ? r_query : i_rec.ip;

    // find the lowest matching slot and the lowest free slot
    always_comb begin
        w_hit = 1'b0; w_hit_idx = '0; w_free = 1'b0; w_free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_ip[i] == w_key) begin
                w_hit = 1'b1; w_hit_idx = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                w_free = 1'b1; w_free_idx = SLOT_W'(i);
            end
        end
    end

    assign w_ins_idx = w_hit ? w_hit_idx : w_free_idx;

    // control state of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.insert_en && i_rec.valid) begin
            if (w_hit || w_free) r_valid[w_ins_idx] <= 1'b1;
            else r_overflow <= 1'b1;
        end else if (i_cmd.lookup_en && w_hit) begin
            r_valid[w_hit_idx] <= 1'b0;
        end
    end

    // slot payload, query and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert_en && i_rec.valid && (w_hit || w_free)) begin
            r_ip[w_ins_idx]   <= i_rec.ip;
            r_mac[w_ins_idx]  <= i_rec.mac;
            r_kind[w_ins_idx] <= i_rec.kind;
        end
        if (i_cmd.query_en) r_query <= i_query;
        if (i_cmd.lookup_en) begin
            r_okind <= w_hit ? r_kind[w_hit_idx] : KIND_NONE;
            r_omac  <= w_hit ? r_mac[w_hit_idx] : '0;
            r_oip   <= w_hit ? r_ip[w_hit_idx] : '0;
            r_oovf  <= r_overflow;
        end
    end

    assign o_kind     = r_okind;
    assign o_mac      = r_omac;
    assign o_ip       = r_oip;
    assign o_overflow = r_oovf;

endmodule

// File: src/arp_icmp_reply_resolution_table.sv
// Top level of the ARP/ICMP reply resolution table.
// Frame bytes (tuser 0) are taken one per cycle while the controller is idle;
// after the byte marked tlast an insert state classifies the frame and writes
// its record to the 16-slot table before more input is taken. A lookup
// (tuser 1) latches the query ip; the lookup state searches the table in
// parallel and loads the result register once any earlier result is taken.
// Each lookup returns exactly one result and removes the entry it finds.
// Overflow is sticky until reset.
module arp_icmp_reply_resolution_table import arpir_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // frame_byte [7:0], query_ip [39:8]
    input  logic        i_s_tlast,  // frame_end
    input  logic [0:0]  i_s_tuser,  // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,  // entry_mac [47:0], entry_ip [79:48],
                                    // overflow_seen [80], zero [87:81]
    output logic [1:0]  o_m_tuser   // entry_kind
);

    t_cmd        w_cmd;
    t_record     w_rec;
    logic [47:0] w_mac;
    logic [31:0] w_ip;
    logic        w_ovf;

    arpir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_s_cmd    (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    arpir_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_byte  (i_s_tdata[7:0]),
        .o_rec   (w_rec)
    );

    arpir_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_rec      (w_rec),
        .i_query    (i_s_tdata[39:8]),
        .o_kind     (o_m_tuser),
        .o_mac      (w_mac),
        .o_ip       (w_ip),
        .o_overflow (w_ovf)
    );

    assign o_m_tdata = {7'd0, w_ovf, w_ip, w_mac};

endmodule
